/* hdl/sunrise_cubic_ramp_warm_cool_mix_core_defines.svh */
// assertion helpers shared by the core
`ifndef SUNRISE_CUBIC_RAMP_WARM_COOL_MIX_CORE_DEFINES_SVH
`define SUNRISE_CUBIC_RAMP_WARM_COOL_MIX_CORE_DEFINES_SVH

// cons must hold in every cycle where ante holds
`define SCRM_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scrm: implication check failed");

// cond must never be seen
`define SCRM_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("scrm: forbidden condition seen");

`endif

/* hdl/scrm_pkg.sv */
package scrm_pkg;

	// field widths
	localparam int ELAPSED_W  = 22;
	localparam int RAMP_W     = 22;
	localparam int Q_W        = 15;
	localparam int PCT_W      = 7;
	localparam int MIN_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int MIX_W      = 14;
	localparam int SC_W       = Q_W + PCT_W;
	localparam int DIVP_W     = 27;

	// ramp timing
	localparam int MS_PER_MINUTE    = 60000;
	localparam int MIN_LO           = 1;
	localparam int MIN_HI           = 60;
	localparam int FALLBACK_MINUTES = 30;
	localparam int FALLBACK_EFF     = (FALLBACK_MINUTES < MIN_LO) ? MIN_LO :
		((FALLBACK_MINUTES > MIN_HI) ? MIN_HI : FALLBACK_MINUTES);
	localparam int RESET_MINUTES    = 30;
	localparam logic [RAMP_W-1:0] RAMP_MS_RESET = RAMP_W'(RESET_MINUTES * MS_PER_MINUTE);

	// register reset values and limits
	localparam logic [PCT_W-1:0] BRI_MAX     = PCT_W'(100);
	localparam logic [PCT_W-1:0] WAKE_RESET  = PCT_W'(100);
	localparam logic [PCT_W-1:0] CTEMP_RESET = PCT_W'(50);

	// rounding constants
	localparam int Q15_HALF     = 1 << 14;
	localparam int MIX_ROUND    = 50;
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_SHIFT = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SUNRISE_MINUTES = 2'd0,
		REG_WAKE_BRIGHTNESS = 2'd1,
		REG_COLOR_TEMP      = 2'd2
	} scrm_reg_t;

	// per-beat control that travels down the pipe
	typedef struct packed {
		logic vld;
		logic dark;
		logic done;
	} scrm_ctl_t;

	// ramp length in ms for a written minute count
	function automatic logic [RAMP_W-1:0] ramp_of(input logic [MIN_W-1:0] m);
		logic [MIN_W-1:0] e;
		e = (m >= MIN_W'(MIN_LO) && m <= MIN_W'(MIN_HI)) ? m : MIN_W'(FALLBACK_EFF);
		return RAMP_W'(e * MS_PER_MINUTE);
	endfunction

endpackage

/* hdl/sunrise_cubic_ramp_warm_cool_mix_core.sv */
// an accepted input beat passes the divider, cube and mix stages in that order to its result beat
// throughput: one beat per cycle; the 16-stage divider (entry plus one per quotient bit) sets the depth
// a stalled output freezes the whole pipe, no beat is lost or repeated
// reset: arst_n clears all valid bits and restores 30 min, 100 %, 50 color temp
`include "sunrise_cubic_ramp_warm_cool_mix_core_defines.svh"

module sunrise_cubic_ramp_warm_cool_mix_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [scrm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [scrm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [scrm_pkg::ELAPSED_W-1:0]    since_start_ms,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [scrm_pkg::PCT_W-1:0]        brightness,
	output logic [scrm_pkg::PCT_W-1:0]        warm_pct,
	output logic [scrm_pkg::PCT_W-1:0]        cool_pct
);
	import scrm_pkg::*;

	logic [RAMP_W-1:0] ramp_ms_q;
	logic [PCT_W-1:0]  wake_q;
	logic [PCT_W-1:0]  ctemp_q;
	logic [PCT_W-1:0]  ct_eff;
	logic              adv;
	scrm_ctl_t         ctl_in, ctl_div, ctl_cube;
	logic [Q_W-1:0]    prog;
	logic [PCT_W-1:0]  bri;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_ms_q <= RAMP_MS_RESET;
			wake_q    <= WAKE_RESET;
			ctemp_q   <= CTEMP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SUNRISE_MINUTES: ramp_ms_q <= ramp_of(cfg_data[MIN_W-1:0]);
				REG_WAKE_BRIGHTNESS: wake_q <= (cfg_data > BRI_MAX) ? BRI_MAX : cfg_data;
				REG_COLOR_TEMP:      ctemp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ct_eff = (ctemp_q > BRI_MAX) ? BRI_MAX : ctemp_q;

	// whole pipe moves unless the output register holds an untaken beat
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// entry flags
	always_comb begin
		ctl_in.vld  = in_valid;
		ctl_in.dark = (wake_q == '0) || (since_start_ms == '0);
		ctl_in.done = (RAMP_W'(since_start_ms) >= ramp_ms_q);
	end

	scrm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_in),
		.elapsed (since_start_ms),
		.ramp_ms (ramp_ms_q),
		.ctl_out (ctl_div),
		.prog    (prog)
	);

	scrm_cube u_cube (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_div),
		.prog    (prog),
		.target  (wake_q),
		.ctl_out (ctl_cube),
		.bri     (bri)
	);

	scrm_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_in   (ctl_cube),
		.bri      (bri),
		.ct       (ct_eff),
		.out_vld  (out_valid),
		.bri_out  (brightness),
		.warm_out (warm_pct),
		.cool_out (cool_pct)
	);

	// checks
	`SCRM_ASSERT_IMPLIES(a_mix_sum, out_valid, (8'(warm_pct) + 8'(cool_pct)) == 8'(brightness))
	`SCRM_ASSERT_IMPLIES(a_dark_mix, out_valid && (brightness == '0), (warm_pct == '0) && (cool_pct == '0))
	`SCRM_ASSERT_NEVER(a_bri_range, out_valid && (brightness > BRI_MAX))
	`SCRM_ASSERT_NEVER(a_stall_only_full, !in_ready && !out_valid)

endmodule

/* hdl/scrm_div.sv */
module scrm_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  scrm_pkg::scrm_ctl_t              ctl_in,
	input  logic [scrm_pkg::ELAPSED_W-1:0]   elapsed,
	input  logic [scrm_pkg::RAMP_W-1:0]      ramp_ms,
	output scrm_pkg::scrm_ctl_t              ctl_out,
	output logic [scrm_pkg::Q_W-1:0]         prog
);
	import scrm_pkg::*;

	scrm_ctl_t         ctl_s [0:Q_W];
	logic [RAMP_W-1:0] rem_s [0:Q_W];
	logic [Q_W-1:0]    quo_s [0:Q_W];

	// entry stage: finished ramps start from zero remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (adv) begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= ctl_in.done ? '0 : RAMP_W'(elapsed);
			quo_s[0] <= '0;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 1; k <= Q_W; k++) begin : g_bit
		logic [RAMP_W:0] sh;
		logic [RAMP_W:0] diff;
		logic            take;

		assign sh   = {rem_s[k-1], 1'b0};
		assign diff = sh - {1'b0, ramp_ms};
		assign take = (sh >= {1'b0, ramp_ms});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (adv) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= take ? diff[RAMP_W-1:0] : sh[RAMP_W-1:0];
				quo_s[k] <= {quo_s[k-1][Q_W-2:0], take};
			end
		end
	end

	assign ctl_out = ctl_s[Q_W];
	assign prog    = quo_s[Q_W];

endmodule

/* hdl/scrm_cube.sv */
module scrm_cube (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  scrm_pkg::scrm_ctl_t          ctl_in,
	input  logic [scrm_pkg::Q_W-1:0]     prog,
	input  logic [scrm_pkg::PCT_W-1:0]   target,
	output scrm_pkg::scrm_ctl_t          ctl_out,
	output logic [scrm_pkg::PCT_W-1:0]   bri
);
	import scrm_pkg::*;

	scrm_ctl_t         ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [Q_W-1:0]    p_s1, p2_s1;
	logic [Q_W-1:0]    p_s2, p3_s2;
	logic [PCT_W-1:0]  bsc_s3;
	logic [PCT_W-1:0]  bri_s4;

	logic [2*Q_W-1:0]  sq_prod;
	logic [2*Q_W-1:0]  cb_prod;
	logic [SC_W-1:0]   sc_prod;
	logic [PCT_W-1:0]  bri_next;

	// q15 square, cube and scale by target with rounding
	assign sq_prod = (2*Q_W)'(prog) * (2*Q_W)'(prog);
	assign cb_prod = (2*Q_W)'(p2_s1) * (2*Q_W)'(p_s1);
	assign sc_prod = SC_W'(p3_s2) * SC_W'(target) + SC_W'(Q15_HALF);

	// dark start, finished ramp, clamp and floor of one
	always_comb begin
		if (ctl_s3.dark) begin
			bri_next = '0;
		end else if (ctl_s3.done) begin
			bri_next = target;
		end else if (bsc_s3 > target) begin
			bri_next = target;
		end else if (bsc_s3 == '0) begin
			bri_next = PCT_W'(1);
		end else begin
			bri_next = bsc_s3;
		end
	end

	// control stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// data stages
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1   <= prog;
			p2_s1  <= sq_prod[2*Q_W-1:Q_W];
			p_s2   <= p_s1;
			p3_s2  <= cb_prod[2*Q_W-1:Q_W];
			bsc_s3 <= sc_prod[Q_W +: PCT_W];
			bri_s4 <= bri_next;
		end
	end

	assign ctl_out = ctl_s4;
	assign bri     = bri_s4;

endmodule

/* hdl/scrm_mix.sv */
module scrm_mix (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  scrm_pkg::scrm_ctl_t          ctl_in,
	input  logic [scrm_pkg::PCT_W-1:0]   bri,
	input  logic [scrm_pkg::PCT_W-1:0]   ct,
	output logic                         out_vld,
	output logic [scrm_pkg::PCT_W-1:0]   bri_out,
	output logic [scrm_pkg::PCT_W-1:0]   warm_out,
	output logic [scrm_pkg::PCT_W-1:0]   cool_out
);
	import scrm_pkg::*;

	logic              vld_s1, vld_s2, vld_s3;
	logic [MIX_W-1:0]  x_s1;
	logic [PCT_W-1:0]  bri_s1, bri_s2, bri_s3;
	logic [PCT_W-1:0]  w_s2;
	logic [PCT_W-1:0]  warm_s3, cool_s3;

	logic [MIX_W-1:0]  x_next;
	logic [DIVP_W-1:0] w_prod;
	logic [PCT_W-1:0]  warm_next, cool_next;

	// warm share before rounding divide
	assign x_next = MIX_W'(bri) * MIX_W'(ct) + MIX_W'(MIX_ROUND);

	// divide by 100 through reciprocal multiply
	assign w_prod = DIVP_W'(x_s1) * DIVP_W'(DIV100_MUL);

	// split; each side that ct lights gets at least one, cool first if brightness allows only one
	always_comb begin
		logic [PCT_W-1:0] w1, c1, w2, c2;
		w1 = (w_s2 > bri_s2) ? bri_s2 : w_s2;
		c1 = bri_s2 - w1;
		w2 = w1;
		c2 = c1;
		if (bri_s2 != '0 && ct != '0 && w1 == '0) begin
			w2 = PCT_W'(1);
			if (c1 != '0) begin
				c2 = c1 - PCT_W'(1);
			end
		end
		warm_next = w2;
		cool_next = c2;
		if (bri_s2 != '0 && ct < BRI_MAX && c2 == '0) begin
			cool_next = PCT_W'(1);
			if (w2 != '0) begin
				warm_next = w2 - PCT_W'(1);
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= ctl_in.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// data stages, last one is the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= x_next;
			bri_s1  <= bri;
			w_s2    <= w_prod[DIV100_SHIFT +: PCT_W];
			bri_s2  <= bri_s1;
			bri_s3  <= bri_s2;
			warm_s3 <= warm_next;
			cool_s3 <= cool_next;
		end
	end

	assign out_vld  = vld_s3;
	assign bri_out  = bri_s3;
	assign warm_out = warm_s3;
	assign cool_out = cool_s3;

endmodule
